// ===== rtl/core/hit_cluster_centroid_accumulator_unit_macros.svh =====
// Assertion macros used by the hit cluster centroid accumulator top level.
`ifndef HIT_CLUSTER_CENTROID_ACCUMULATOR_UNIT_MACROS_SVH
`define HIT_CLUSTER_CENTROID_ACCUMULATOR_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Consequent checked in the same cycle as the antecedent.
`define HCCA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Consequent checked in the cycle after the antecedent.
`define HCCA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define HCCA_ASSERT_SAME(lbl, ante, cons, msg)
`define HCCA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/hcca_pkg.sv =====
// Types and constants of the hit cluster centroid accumulator.
package hcca_pkg;

	localparam int FIBER_W  = 10;
	localparam int TIME_W   = 32;
	localparam int WEIGHT_W = 16;
	localparam int LAYER_W  = 4;
	localparam int TDC_W    = 4;
	localparam int COUNT_W  = 9;
	localparam int WSUM_W   = 24;
	localparam int FMOM_W   = 34;
	localparam int TMOM_W   = 56;
	localparam int MEANF_W  = 18;
	localparam int MEANT_W  = 40;
	localparam int INV_W    = 17;
	localparam int Q8_SHIFT = 8;
	localparam int FPROD_W  = FIBER_W + WEIGHT_W;
	localparam int TPROD_W  = TIME_W + WEIGHT_W;
	localparam int RECIP_W  = 33;

	// operation codes
	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// 2^32, dividend of the reciprocal ahead of the square root
	localparam logic [RECIP_W-1:0] RECIP_NUM = {1'b1, {(RECIP_W-1){1'b0}}};
	// 1.0 in Q16
	localparam logic [INV_W-1:0] INV_SQRT_ONE = {1'b1, {(INV_W-1){1'b0}}};

	typedef struct packed {
		logic                operation;
		logic [FIBER_W-1:0]  fiber_number;
		logic [TIME_W-1:0]   hit_time;
		logic [WEIGHT_W-1:0] tot_weight;
		logic [LAYER_W-1:0]  layer_id;
		logic [TDC_W-1:0]    tdc_number;
	} hcca_req_t;

	typedef struct packed {
		logic                accepted;
		logic [COUNT_W-1:0]  signal_count;
		logic [WSUM_W-1:0]   charge_total;
		logic [WEIGHT_W-1:0] charge_max;
		logic [MEANF_W-1:0]  mean_fiber_q8;
		logic [MEANT_W-1:0]  mean_time_q8;
		logic [INV_W-1:0]    inv_sqrt_weight_q16;
		logic [TIME_W-1:0]   earliest_time;
		logic [LAYER_W-1:0]  cluster_layer;
		logic [TDC_W-1:0]    last_tdc;
	} hcca_rsp_t;

endpackage

// ===== rtl/core/hcca_serial_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module hcca_serial_mul
	import hcca_pkg::*;
#(
	parameter int A_W = 10,
	parameter int B_W = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	output logic               busy,
	output logic [A_W+B_W-1:0] prod
);

	localparam int CNT_W = $clog2(B_W + 1);

	logic [A_W-1:0]     a_q;
	logic [A_W+B_W-1:0] p_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic [A_W:0]       sum;

	// upper half plus multiplicand when the current multiplier bit is set
	assign sum = {1'b0, p_q[A_W+B_W-1:B_W]} + (p_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(B_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			p_q <= {{A_W{1'b0}}, b};
		end else if (busy_q) begin
			p_q <= {sum, p_q[B_W-1:1]};
		end
	end

	assign busy = busy_q;
	assign prod = p_q;

endmodule

// ===== rtl/core/hcca_serial_div.sv =====
// Restoring divider, one quotient bit per cycle.
module hcca_serial_div
	import hcca_pkg::*;
#(
	parameter int D_W = 24,
	parameter int Q_W = 18
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [D_W-1:0] rem_init,   // upper dividend bits, must be below den
	input  logic [Q_W-1:0] low,        // remaining dividend bits, MSB first
	input  logic [D_W-1:0] den,
	output logic           busy,
	output logic [Q_W-1:0] quo
);

	localparam int CNT_W = $clog2(Q_W + 1);

	logic [D_W-1:0]   den_q;
	logic [D_W-1:0]   rem_q;
	logic [Q_W-1:0]   sh_q;       // dividend bits shift out, quotient bits shift in
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [D_W:0]     trial;
	logic [D_W+1:0]   diff;
	logic             ge;

	assign trial = {rem_q, sh_q[Q_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};
	assign ge    = !diff[D_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(Q_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= rem_init;
			sh_q  <= low;
		end else if (busy_q) begin
			rem_q <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
			sh_q  <= {sh_q[Q_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = sh_q;

endmodule

// ===== rtl/core/hcca_isqrt.sv =====
// Restoring integer square root, one root bit per cycle.
module hcca_isqrt
	import hcca_pkg::*;
#(
	parameter int R_W = 17
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [2*R_W-1:0] radicand,
	output logic             busy,
	output logic [R_W-1:0]   root
);

	localparam int CNT_W = $clog2(R_W + 1);

	logic [2*R_W-1:0] op_q;
	logic [R_W:0]     rem_q;
	logic [R_W-1:0]   root_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [R_W+2:0]   rem2;
	logic [R_W+2:0]   trial;
	logic [R_W+3:0]   diff;
	logic             ge;

	// bring down two radicand bits, try 4*root+1
	assign rem2  = {rem_q, op_q[2*R_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign diff  = {1'b0, rem2} - {1'b0, trial};
	assign ge    = !diff[R_W+3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(R_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q   <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			op_q   <= {op_q[2*R_W-3:0], 2'b00};
			rem_q  <= ge ? diff[R_W:0] : rem2[R_W:0];
			root_q <= {root_q[R_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

// ===== rtl/core/hit_cluster_centroid_accumulator_unit.sv =====
// Top level of the hit cluster centroid accumulator: control, cluster state, result register.
// Usage: one request channel (req_valid/req_stall/req) and one result channel
// (res_valid/res_stall/res). A request is taken when req_valid is high and
// req_stall is low; it either adds a signal (operation OP_ADD) or clears the
// cluster (OP_CLEAR). Every request yields exactly one result.
// Sequence: an add that joins the cluster runs two 16-step serial multipliers,
// three serial dividers (the 40-step time-mean divider is the longest) and a
// 17-step square root, then waits in S_FIN until the result register loads.
// A clear or a rejected add goes straight to S_FIN; an add that leaves the
// total weight at zero runs the multipliers, then skips from S_LAUNCH to S_FIN.
// One request at a time: req_stall is high from acceptance until the result
// is loaded into the result register.
// Stall: the result register holds its value while res_valid and res_stall are high. The
// next request may be taken meanwhile, but its result waits for the register.
// Reset: arst_n empties the cluster, drops res_valid and readies the block.
`include "hit_cluster_centroid_accumulator_unit_macros.svh"

module hit_cluster_centroid_accumulator_unit
	import hcca_pkg::*;
#(
	parameter int MAX_SIGNALS = 256,
	parameter int FIBER_BITS  = 10,
	parameter int TIME_BITS   = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  hcca_req_t req,
	output logic      res_valid,
	input  logic      res_stall,
	output hcca_rsp_t res
);

	// only the low FIBER_BITS / TIME_BITS of the fields take part
	localparam logic [FIBER_W-1:0] FIBER_MASK = (FIBER_BITS >= FIBER_W) ? {FIBER_W{1'b1}} :
		FIBER_W'((64'd1 << FIBER_BITS) - 64'd1);
	localparam logic [TIME_W-1:0] TIME_MASK = (TIME_BITS >= TIME_W) ? {TIME_W{1'b1}} :
		TIME_W'((64'd1 << TIME_BITS) - 64'd1);
	localparam int WADD_W = WSUM_W + 1;
	localparam int FADD_W = FMOM_W + 1;
	localparam int TADD_W = TMOM_W + 1;
	localparam int FLOW_W = FMOM_W - WSUM_W;   // moment bits below the divider's first window
	localparam int TLOW_W = TMOM_W - WSUM_W;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_MUL    = 6'b000010,
		S_LAUNCH = 6'b000100,
		S_DIV    = 6'b001000,
		S_SQRT   = 6'b010000,
		S_FIN    = 6'b100000
	} state_t;

	state_t state_q;

	// cluster state
	logic [COUNT_W-1:0]  count_q;
	logic [WSUM_W-1:0]   wsum_q;
	logic [FMOM_W-1:0]   fmom_q;
	logic [TMOM_W-1:0]   tmom_q;
	logic [WEIGHT_W-1:0] wmax_q;
	logic [TIME_W-1:0]   first_q;
	logic [LAYER_W-1:0]  layer_q;
	logic [TDC_W-1:0]    tdc_q;

	// derived values, kept until the cluster changes; acc_q is set by every request
	logic [MEANF_W-1:0]  mean_f_q;
	logic [MEANT_W-1:0]  mean_t_q;
	logic [INV_W-1:0]    inv_q;
	logic                sat_f_q;
	logic                sat_t_q;
	logic                acc_q;

	hcca_rsp_t           res_q;
	logic                res_valid_q;

	// request decode
	logic [FIBER_W-1:0]  fiber_m;
	logic [TIME_W-1:0]   time_m;
	logic                full;
	logic                mismatch;
	logic                take;
	logic                fire;
	logic                mul_start;
	logic [WADD_W-1:0]   wsum_add;

	// datapath units
	logic                mul_f_busy;
	logic                mul_t_busy;
	logic [FPROD_W-1:0]  prod_f;
	logic [TPROD_W-1:0]  prod_t;
	logic [FADD_W-1:0]   fsum;
	logic [TADD_W-1:0]   tsum;
	logic                div_start;
	logic                div_f_busy;
	logic                div_t_busy;
	logic                div_r_busy;
	logic                div_busy;
	logic [MEANF_W-1:0]  quo_f;
	logic [MEANT_W-1:0]  quo_t;
	logic [RECIP_W-1:0]  quo_r;
	logic                sqrt_start;
	logic                sqrt_busy;
	logic [INV_W-1:0]    root;
	logic                res_load;

	assign req_stall = (state_q != S_IDLE);
	assign fire      = req_valid && !req_stall;

	assign fiber_m  = req.fiber_number & FIBER_MASK;
	assign time_m   = req.hit_time & TIME_MASK;
	assign full     = (32'(count_q) >= MAX_SIGNALS);
	assign mismatch = (count_q != '0) && (req.layer_id != layer_q);
	assign take     = (req.operation == OP_ADD) && !full && !mismatch;
	assign mul_start = fire && take;
	assign wsum_add = {1'b0, wsum_q} + WADD_W'(req.tot_weight);

	// saturating moment updates
	assign fsum = {1'b0, fmom_q} + FADD_W'(prod_f);
	assign tsum = {1'b0, tmom_q} + TADD_W'(prod_t);

	assign div_start  = (state_q == S_LAUNCH) && (wsum_q != '0);
	assign div_busy   = div_f_busy || div_t_busy || div_r_busy;
	assign sqrt_start = (state_q == S_DIV) && !div_busy;
	assign res_load   = (state_q == S_FIN) && (!res_valid_q || !res_stall);

	// weight times fiber and weight times time, one weight bit per cycle
	hcca_serial_mul #(.A_W(FIBER_W), .B_W(WEIGHT_W)) u_mul_f (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (fiber_m),
		.b      (req.tot_weight),
		.busy   (mul_f_busy),
		.prod   (prod_f)
	);

	hcca_serial_mul #(.A_W(TIME_W), .B_W(WEIGHT_W)) u_mul_t (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (time_m),
		.b      (req.tot_weight),
		.busy   (mul_t_busy),
		.prod   (prod_t)
	);

	// Q8 means: (moment << 8) / weight_sum. The first divider window is the
	// moment's top WSUM_W bits; when that window is not below the divisor the
	// quotient overflows the field and the mean saturates instead.
	hcca_serial_div #(.D_W(WSUM_W), .Q_W(MEANF_W)) u_div_f (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.rem_init (fmom_q[FMOM_W-1 -: WSUM_W]),
		.low      ({fmom_q[FLOW_W-1:0], {Q8_SHIFT{1'b0}}}),
		.den      (wsum_q),
		.busy     (div_f_busy),
		.quo      (quo_f)
	);

	hcca_serial_div #(.D_W(WSUM_W), .Q_W(MEANT_W)) u_div_t (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.rem_init (tmom_q[TMOM_W-1 -: WSUM_W]),
		.low      ({tmom_q[TLOW_W-1:0], {Q8_SHIFT{1'b0}}}),
		.den      (wsum_q),
		.busy     (div_t_busy),
		.quo      (quo_t)
	);

	// floor(2^32 / weight_sum); its integer square root is the largest y
	// with y*y*weight_sum <= 2^32
	hcca_serial_div #(.D_W(WSUM_W), .Q_W(RECIP_W)) u_div_r (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.rem_init ('0),
		.low      (RECIP_NUM),
		.den      (wsum_q),
		.busy     (div_r_busy),
		.quo      (quo_r)
	);

	hcca_isqrt #(.R_W(INV_W)) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand ({1'b0, quo_r}),
		.busy     (sqrt_busy),
		.root     (root)
	);

	// control and cluster state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			wsum_q   <= '0;
			fmom_q   <= '0;
			tmom_q   <= '0;
			wmax_q   <= '0;
			first_q  <= '0;
			layer_q  <= '0;
			tdc_q    <= '0;
			mean_f_q <= '0;
			mean_t_q <= '0;
			inv_q    <= INV_SQRT_ONE;
			sat_f_q  <= 1'b0;
			sat_t_q  <= 1'b0;
			acc_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (fire) begin
						if (req.operation == OP_CLEAR) begin
							count_q  <= '0;
							wsum_q   <= '0;
							fmom_q   <= '0;
							tmom_q   <= '0;
							wmax_q   <= '0;
							first_q  <= '0;
							layer_q  <= '0;
							tdc_q    <= '0;
							mean_f_q <= '0;
							mean_t_q <= '0;
							inv_q    <= INV_SQRT_ONE;
							acc_q    <= 1'b0;
							state_q  <= S_FIN;
						end else if (take) begin
							count_q <= count_q + 1'b1;
							wsum_q  <= wsum_add[WSUM_W] ? '1 : wsum_add[WSUM_W-1:0];
							if (req.tot_weight > wmax_q) begin
								wmax_q <= req.tot_weight;
							end
							if ((first_q == '0) || (time_m < first_q)) begin
								first_q <= time_m;
							end
							layer_q <= req.layer_id;
							tdc_q   <= req.tdc_number;
							acc_q   <= 1'b1;
							state_q <= S_MUL;
						end else begin
							// rejected: cluster and its means stay as they are
							acc_q   <= 1'b0;
							state_q <= S_FIN;
						end
					end
				end
				S_MUL: begin
					if (!mul_f_busy && !mul_t_busy) begin
						fmom_q  <= fsum[FMOM_W] ? '1 : fsum[FMOM_W-1:0];
						tmom_q  <= tsum[TMOM_W] ? '1 : tsum[TMOM_W-1:0];
						state_q <= S_LAUNCH;
					end
				end
				S_LAUNCH: begin
					if (wsum_q == '0) begin
						mean_f_q <= '0;
						mean_t_q <= '0;
						inv_q    <= INV_SQRT_ONE;
						state_q  <= S_FIN;
					end else begin
						sat_f_q <= (fmom_q[FMOM_W-1 -: WSUM_W] >= wsum_q);
						sat_t_q <= (tmom_q[TMOM_W-1 -: WSUM_W] >= wsum_q);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (!div_busy) begin
						mean_f_q <= sat_f_q ? '1 : quo_f;
						mean_t_q <= sat_t_q ? '1 : quo_t;
						state_q  <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (!sqrt_busy) begin
						inv_q   <= root;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.accepted            <= acc_q;
			res_q.signal_count        <= count_q;
			res_q.charge_total        <= wsum_q;
			res_q.charge_max          <= wmax_q;
			res_q.mean_fiber_q8       <= mean_f_q;
			res_q.mean_time_q8        <= mean_t_q;
			res_q.inv_sqrt_weight_q16 <= inv_q;
			res_q.earliest_time       <= first_q;
			res_q.cluster_layer       <= layer_q;
			res_q.last_tdc            <= tdc_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`HCCA_ASSERT_NEXT(a_take_leaves_idle, fire, state_q != S_IDLE, "request taken but control stayed idle")
	`HCCA_ASSERT_SAME(a_units_quiet, (state_q == S_IDLE) || (state_q == S_FIN), !mul_f_busy && !mul_t_busy && !div_busy && !sqrt_busy, "arithmetic unit busy outside a computation")
	`HCCA_ASSERT_SAME(a_max_within_total, res_valid_q, res_q.charge_max <= res_q.charge_total, "largest weight exceeds total weight")
	`HCCA_ASSERT_SAME(a_empty_weight_result, res_valid_q && (res_q.charge_total == '0), (res_q.mean_fiber_q8 == '0) && (res_q.mean_time_q8 == '0) && (res_q.inv_sqrt_weight_q16 == INV_SQRT_ONE), "zero total weight with nonzero means or wrong inverse root")

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the hit cluster centroid accumulator: directed table, full cluster, random.
module testbench;
	import hcca_pkg::*;

	// Design point of the block as instantiated (default parameters)
	localparam int MAX_SIGNALS     = 256;
	localparam int ITEM_TARGET     = 1000;
	localparam int FILL_ADDS       = MAX_SIGNALS + 6;  // runs past full on purpose
	localparam int HOLD_OFF_CYCLES = 600;
	localparam int DRAIN_CYCLES    = 100;
	localparam int IDLE_LIMIT      = 5000;

	// One row of the directed table; rs is used only when typed is set
	typedef struct packed {
		logic      typed;
		hcca_req_t rq;
		hcca_rsp_t rs;
	} dir_row_t;

	logic      clk;
	logic      arst_n = 1'b0;
	logic      req_valid;
	logic      req_stall;
	hcca_req_t req;
	logic      res_valid;
	logic      res_stall;
	hcca_rsp_t res;

	hit_cluster_centroid_accumulator_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	// Shadow copy of the cluster state
	logic [COUNT_W-1:0]  cl_count;
	logic [WSUM_W-1:0]   cl_wsum;
	logic [FMOM_W-1:0]   cl_fmom;
	logic [TMOM_W-1:0]   cl_tmom;
	logic [WEIGHT_W-1:0] cl_wmax;
	logic [TIME_W-1:0]   cl_first;
	logic [LAYER_W-1:0]  cl_layer;
	logic [TDC_W-1:0]    cl_tdc;

	hcca_rsp_t pending_results[$];
	dir_row_t  directed_rows[$];

	int error_count = 0;
	int sent_count  = 0;
	bit calm        = 1'b0;  // no random gaps on either side while set
	bit hold_off_req = 1'b0; // asks the result side for one long stall

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void clear_cluster();
		cl_count = '0;
		cl_wsum  = '0;
		cl_fmom  = '0;
		cl_tmom  = '0;
		cl_wmax  = '0;
		cl_first = '0;
		cl_layer = '0;
		cl_tdc   = '0;
	endfunction

	function automatic logic [63:0] saturate(logic [63:0] s, int w);
		logic [63:0] lim;
		lim = (64'd1 << w) - 64'd1;
		return (s > lim) ? lim : s;
	endfunction

	// floor(num * 256 / den), clipped to a w-bit field
	function automatic logic [63:0] q8_mean(logic [63:0] num, logic [WSUM_W-1:0] den, int w);
		logic [71:0] q;
		logic [71:0] lim;
		q   = ({8'd0, num} << Q8_SHIFT) / 72'(den);
		lim = (72'd1 << w) - 72'd1;
		return (q > lim) ? lim[63:0] : q[63:0];
	endfunction

	// Applies one request to the shadow cluster and returns the result it yields
	function automatic hcca_rsp_t predict_cluster(hcca_req_t r);
		hcca_rsp_t   o;
		logic        joins;
		logic [63:0] y;
		logic [63:0] trial;
		int          b;
		joins = 1'b0;
		if (r.operation == OP_CLEAR) begin
			clear_cluster();
		end else if (32'(cl_count) < MAX_SIGNALS &&
				!(cl_count != '0 && r.layer_id != cl_layer)) begin
			joins    = 1'b1;
			cl_count = cl_count + 1'b1;
			cl_wsum  = WSUM_W'(saturate(64'(cl_wsum) + 64'(r.tot_weight), WSUM_W));
			cl_fmom  = FMOM_W'(saturate(64'(cl_fmom) +
				64'(r.tot_weight) * 64'(r.fiber_number), FMOM_W));
			cl_tmom  = TMOM_W'(saturate(64'(cl_tmom) +
				64'(r.tot_weight) * 64'(r.hit_time), TMOM_W));
			if (r.tot_weight > cl_wmax)
				cl_wmax = r.tot_weight;
			// a stored zero timestamp means unset
			if (cl_first == '0 || r.hit_time < cl_first)
				cl_first = r.hit_time;
			cl_layer = r.layer_id;
			cl_tdc   = r.tdc_number;
		end
		o.accepted      = joins;
		o.signal_count  = cl_count;
		o.charge_total  = cl_wsum;
		o.charge_max    = cl_wmax;
		o.earliest_time = cl_first;
		o.cluster_layer = cl_layer;
		o.last_tdc      = cl_tdc;
		if (cl_wsum == '0) begin
			o.mean_fiber_q8       = '0;
			o.mean_time_q8        = '0;
			o.inv_sqrt_weight_q16 = INV_SQRT_ONE;
		end else begin
			o.mean_fiber_q8 = MEANF_W'(q8_mean(64'(cl_fmom), cl_wsum, MEANF_W));
			o.mean_time_q8  = MEANT_W'(q8_mean(64'(cl_tmom), cl_wsum, MEANT_W));
			// largest y with y*y*weight <= 2^32, one bit at a time
			y = '0;
			for (b = INV_W - 1; b >= 0; b--) begin
				trial = y | (64'd1 << b);
				if (trial <= 64'(INV_SQRT_ONE) && trial * trial * 64'(cl_wsum) <= (64'd1 << 32))
					y = trial;
			end
			o.inv_sqrt_weight_q16 = INV_W'(y);
		end
		return o;
	endfunction

	function automatic hcca_req_t mk_req(logic op, logic [FIBER_W-1:0] fib,
			logic [TIME_W-1:0] t, logic [WEIGHT_W-1:0] w, logic [LAYER_W-1:0] layer,
			logic [TDC_W-1:0] tdc);
		hcca_req_t r;
		r.operation    = op;
		r.fiber_number = fib;
		r.hit_time     = t;
		r.tot_weight   = w;
		r.layer_id     = layer;
		r.tdc_number   = tdc;
		return r;
	endfunction

	function automatic hcca_rsp_t mk_rsp(logic acc, logic [COUNT_W-1:0] cnt,
			logic [WSUM_W-1:0] total, logic [WEIGHT_W-1:0] wmax, logic [MEANF_W-1:0] mf,
			logic [MEANT_W-1:0] mt, logic [INV_W-1:0] inv, logic [TIME_W-1:0] first,
			logic [LAYER_W-1:0] layer, logic [TDC_W-1:0] tdc);
		hcca_rsp_t o;
		o.accepted            = acc;
		o.signal_count        = cnt;
		o.charge_total        = total;
		o.charge_max          = wmax;
		o.mean_fiber_q8       = mf;
		o.mean_time_q8        = mt;
		o.inv_sqrt_weight_q16 = inv;
		o.earliest_time       = first;
		o.cluster_layer       = layer;
		o.last_tdc            = tdc;
		return o;
	endfunction

	// Random add with extremes mixed in; layer chosen by the caller
	function automatic hcca_req_t random_signal(logic [LAYER_W-1:0] layer);
		hcca_req_t r;
		int        pick;
		r.operation = OP_ADD;
		pick = $urandom_range(0, 15);
		r.fiber_number = (pick == 0) ? '0 : (pick == 1) ? '1 : FIBER_W'($urandom);
		pick = $urandom_range(0, 19);
		r.hit_time = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom;
		pick = $urandom_range(0, 19);
		r.tot_weight = (pick == 0) ? '0 : (pick == 1) ? '1 :
			(pick < 5) ? WEIGHT_W'($urandom_range(1, 15)) : WEIGHT_W'($urandom);
		r.layer_id   = layer;
		r.tdc_number = TDC_W'($urandom);
		return r;
	endfunction

	// Mostly back to back, sometimes a short gap, rarely a long pause; always back to back while calm
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 4);
		return $urandom_range(20, 150);
	endfunction

	// Offer one request and hold it until taken; the caller is left at the accepting edge
	task automatic offer_request(hcca_req_t item, logic typed, hcca_rsp_t typed_rsp);
		int        gap;
		hcca_rsp_t predicted;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (req_stall);
		predicted = predict_cluster(item);
		pending_results.push_back(typed ? typed_rsp : predicted);
		sent_count++;
	endtask

	// Sender stops and waits for every outstanding result
	task automatic drain_results();
		req_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic compare_field(string name, logic [63:0] expv, logic [63:0] act);
		if (expv !== act) begin
			$error("%s: expected %0d, actual %0d", name, expv, act);
			error_count++;
		end
	endtask

	task automatic check_result(hcca_rsp_t got);
		hcca_rsp_t want;
		if (pending_results.size() == 0) begin
			$error("result with no request outstanding");
			error_count++;
		end else begin
			want = pending_results.pop_front();
			compare_field("accepted", 64'(want.accepted), 64'(got.accepted));
			compare_field("signal_count", 64'(want.signal_count), 64'(got.signal_count));
			compare_field("charge_total", 64'(want.charge_total), 64'(got.charge_total));
			compare_field("charge_max", 64'(want.charge_max), 64'(got.charge_max));
			compare_field("mean_fiber_q8", 64'(want.mean_fiber_q8), 64'(got.mean_fiber_q8));
			compare_field("mean_time_q8", 64'(want.mean_time_q8), 64'(got.mean_time_q8));
			compare_field("inv_sqrt_weight_q16", 64'(want.inv_sqrt_weight_q16),
				64'(got.inv_sqrt_weight_q16));
			compare_field("earliest_time", 64'(want.earliest_time), 64'(got.earliest_time));
			compare_field("cluster_layer", 64'(want.cluster_layer), 64'(got.cluster_layer));
			compare_field("last_tdc", 64'(want.last_tdc), 64'(got.last_tdc));
		end
	endtask

	// Result side: checks every taken result and drives stall with random gaps
	initial begin : result_side
		int stall_left;
		stall_left = 0;
		res_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (res_valid && !res_stall)
				check_result(res);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall_left   = HOLD_OFF_CYCLES;
			end else if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
			end
			if (stall_left > 0) begin
				res_stall <= 1'b1;
				stall_left--;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	// Watchdog: ends the run if neither channel moves for too long
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		wait (arst_n === 1'b1);
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (res_valid && !res_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$error("no request or result moved for %0d cycles", IDLE_LIMIT);
		$display("testbench: done, errors");
		$finish;
	end

	// Request side: directed table, full-cluster burst, then random clusters
	initial begin : request_side
		hcca_rsp_t   empty_rsp;
		hcca_rsp_t   no_rsp;
		hcca_req_t   item;
		logic [3:0]  layer;
		int          n;
		bit          paused;

		req_valid <= 1'b0;
		req       <= '0;
		clear_cluster();
		empty_rsp = mk_rsp(1'b0, '0, '0, '0, '0, '0, INV_SQRT_ONE, '0, '0, '0);
		no_rsp    = '0;
		paused    = 1'b0;

		// typed rows carry an expectation readable at a glance; others use the predictor
		directed_rows.push_back({1'b1, mk_req(OP_CLEAR, 0, 0, 0, 0, 0), empty_rsp});
		// zero weight: means stay 0 and the inverse root reads 1.0
		directed_rows.push_back({1'b1, mk_req(OP_ADD, 5, 100, 0, 3, 2),
			mk_rsp(1'b1, 1, 0, 0, 0, 0, INV_SQRT_ONE, 100, 3, 2)});
		directed_rows.push_back({1'b1, mk_req(OP_ADD, '1, '1, 1, 3, 15),
			mk_rsp(1'b1, 2, 1, 1, 18'd261888, 40'hFF_FFFF_FF00, INV_SQRT_ONE, 100, 3, 15)});
		// layer mismatch: state unchanged, not accepted
		directed_rows.push_back({1'b1, mk_req(OP_ADD, 7, 9, 50, 4, 6),
			mk_rsp(1'b0, 2, 1, 1, 18'd261888, 40'hFF_FFFF_FF00, INV_SQRT_ONE, 100, 3, 15)});
		directed_rows.push_back({1'b1, mk_req(OP_CLEAR, 0, 0, 0, 0, 0), empty_rsp});
		directed_rows.push_back({1'b1, mk_req(OP_ADD, '1, '1, '1, 15, 0),
			mk_rsp(1'b1, 1, 24'd65535, '1, 18'd261888, 40'hFF_FFFF_FF00, 17'd256, '1, 15, 0)});
		// zero timestamp after a set one: stored as 0, i.e. unset again
		directed_rows.push_back({1'b0, mk_req(OP_ADD, 0, 0, '1, 15, 9), no_rsp});
		directed_rows.push_back({1'b0, mk_req(OP_ADD, 512, 5, 100, 15, 1), no_rsp});
		directed_rows.push_back({1'b0, mk_req(OP_ADD, 0, 0, 0, 0, 0), no_rsp});
		// clear ignores its payload
		directed_rows.push_back({1'b1, mk_req(OP_CLEAR, '1, '1, '1, '1, '1), empty_rsp});
		directed_rows.push_back({1'b1, mk_req(OP_ADD, 0, 0, 0, 0, 0),
			mk_rsp(1'b1, 1, 0, 0, 0, 0, INV_SQRT_ONE, 0, 0, 0)});
		directed_rows.push_back({1'b0, mk_req(OP_ADD, 300, 1234, 9, 7, 3), no_rsp});
		directed_rows.push_back({1'b1, mk_req(OP_CLEAR, 10'h2AA, 32'h5555_AAAA, 16'hA5A5, 10, 5),
			empty_rsp});
		directed_rows.push_back({1'b1, mk_req(OP_ADD, 0, 0, 4, 0, 0),
			mk_rsp(1'b1, 1, 4, 4, 0, 0, 17'd32768, 0, 0, 0)});
		directed_rows.push_back({1'b0, mk_req(OP_ADD, '1, 32'h8000_0000, '1, 0, 5), no_rsp});
		directed_rows.push_back({1'b0, mk_req(OP_ADD, 1, 1, '1, 0, 10), no_rsp});
		directed_rows.push_back({1'b0, mk_req(OP_ADD, 10'h155, 32'h1234_5678, 16'h5A5A, 0, 12),
			no_rsp});
		directed_rows.push_back({1'b1, mk_req(OP_CLEAR, 0, 0, 0, 0, 0), empty_rsp});

		// single reset pulse
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			offer_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].rs);
		drain_results();

		// Full cluster: one layer, six adds past MAX_SIGNALS. The result side holds off
		// at the start while requests keep coming, so the block backs up.
		calm = 1'b1;
		hold_off_req = 1'b1;
		layer = 4'($urandom);
		for (int k = 0; k < FILL_ADDS; k++) begin
			if (k == 40)
				calm = 1'b0;
			offer_request(random_signal(layer), 1'b0, no_rsp);
		end
		item = random_signal(layer);
		item.operation = OP_CLEAR;
		offer_request(item, 1'b0, no_rsp);

		// Random clusters: mostly one layer then a clear, with stray layers and noise
		while (sent_count < ITEM_TARGET) begin
			calm = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 6) == 0) begin
				item = random_signal(4'($urandom));
				item.operation = ($urandom_range(0, 3) == 0) ? OP_CLEAR : OP_ADD;
				offer_request(item, 1'b0, no_rsp);
			end else begin
				layer = 4'($urandom);
				n = $urandom_range(1, 24);
				repeat (n) begin
					item = random_signal(($urandom_range(0, 9) == 0) ? 4'($urandom) : layer);
					offer_request(item, 1'b0, no_rsp);
				end
				item = random_signal(4'($urandom));
				item.operation = OP_CLEAR;
				offer_request(item, 1'b0, no_rsp);
			end
			if (!paused && sent_count >= 600) begin
				paused = 1'b1;
				drain_results();
			end
		end
		calm = 1'b0;

		// wind down: all results in, then a quiet stretch for strays
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
